[rtl/vdbs_pkg.sv]
// Shared types, codes and constants of the viewdata byte stream decoder.
`timescale 1ns / 1ps

package vdbs_pkg;

  // Default screen geometry.
  localparam int unsigned COLUMNS_DEF = 40;
  localparam int unsigned ROWS_DEF    = 24;

  // Depth of the command queue between front and back (a power of two).
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Marker for "no lower-half row".
  localparam logic [5:0] LOW_NONE    = 6'h3F;
  localparam logic [8:0] SPACE_GLYPH = 9'h020;

  // Cursor control codes (seven-bit values).
  localparam logic [6:0] C_NUL = 7'd0;
  localparam logic [6:0] C_BS  = 7'd8;
  localparam logic [6:0] C_HT  = 7'd9;
  localparam logic [6:0] C_LF  = 7'd10;
  localparam logic [6:0] C_VT  = 7'd11;
  localparam logic [6:0] C_FF  = 7'd12;
  localparam logic [6:0] C_CR  = 7'd13;
  localparam logic [6:0] C_DC1 = 7'd17;
  localparam logic [6:0] C_DC4 = 7'd20;
  localparam logic [6:0] C_RS  = 7'd30;

  // Attribute column codes.
  localparam logic [2:0] COL_ATTR0 = 3'd0;
  localparam logic [2:0] COL_ATTR1 = 3'd1;

  // Attribute row codes in column 0.
  localparam logic [3:0] A0_NUL       = 4'd0;
  localparam logic [3:0] A0_FLASH     = 4'd8;
  localparam logic [3:0] A0_STEADY    = 4'd9;
  localparam logic [3:0] A0_END_BOX   = 4'd10;
  localparam logic [3:0] A0_START_BOX = 4'd11;
  localparam logic [3:0] A0_NORMAL    = 4'd12;
  localparam logic [3:0] A0_DOUBLE    = 4'd13;
  localparam logic [3:0] A0_SO        = 4'd14;
  localparam logic [3:0] A0_SI        = 4'd15;

  // Attribute row codes in column 1.
  localparam logic [3:0] A1_DLE       = 4'd0;
  localparam logic [3:0] A1_CONCEAL   = 4'd8;
  localparam logic [3:0] A1_CONTIG    = 4'd9;
  localparam logic [3:0] A1_SEPARATED = 4'd10;
  localparam logic [3:0] A1_ESC       = 4'd11;
  localparam logic [3:0] A1_BLACK_BG  = 4'd12;
  localparam logic [3:0] A1_NEW_BG    = 4'd13;
  localparam logic [3:0] A1_HOLD      = 4'd14;
  localparam logic [3:0] A1_RELEASE   = 4'd15;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_SINGLE = 3'd0,
    KIND_UPPER  = 3'd1,
    KIND_LOWER  = 3'd2,
    KIND_REPORT = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_t;

  // Phases of the back end while it expands one command.
  typedef enum logic [1:0] {
    PH_CLEAR  = 2'd0,
    PH_CELL   = 2'd1,
    PH_LOWER  = 2'd2,
    PH_REPORT = 2'd3
  } phase_t;

  // Serial attribute flags of the current row.
  typedef struct packed {
    logic alpha;
    logic contig;
    logic flash;
    logic conceal;
    logic hold;
    logic dbl;
    logic esc;
  } mode_t;

  localparam mode_t MODE_RESET = '{alpha: 1'b1, contig: 1'b1, flash: 1'b0,
                                   conceal: 1'b0, hold: 1'b0, dbl: 1'b0,
                                   esc: 1'b0};

  // One classified byte: everything the back end needs to produce its results.
  typedef struct packed {
    logic       has_clr;
    logic       has_cell;
    logic       has_low;
    kind_t      cell_kind;
    logic [4:0] cell_row;
    logic [5:0] cell_col;
    logic [4:0] low_row;
    logic [8:0] glyph;
    logic [2:0] fg;
    logic [2:0] bg;
    logic       flash;
    logic       conceal;
    logic [4:0] rep_row;
    logic [5:0] rep_col;
    logic       cursor_on;
  } cmd_t;

  // One result as held in the output register.
  typedef struct packed {
    logic       last;
    kind_t      cell_kind;
    logic [4:0] row;
    logic [5:0] col;
    logic [6:0] char_code;
    logic       is_mosaic;
    logic       separated;
    logic [2:0] fg_color;
    logic [2:0] bkgd_color;
    logic       flash;
    logic       conceal;
    logic       cursor_on;
  } res_t;

endpackage

[rtl/vdbs_ifs.sv]
// Channel interfaces of the decoder: received bytes in, cell results out.
`timescale 1ns / 1ps

interface vdbs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface vdbs_result_if;
  logic       valid;
  logic       ready;
  logic       last;
  logic [2:0] cell_kind;
  logic [4:0] row;
  logic [5:0] col;
  logic [6:0] char_code;
  logic       is_mosaic;
  logic       separated;
  logic [2:0] fg_color;
  logic [2:0] bkgd_color;
  logic       flash;
  logic       conceal;
  logic       cursor_on;

  modport source (output valid, output last, output cell_kind, output row, output col,
                  output char_code, output is_mosaic, output separated,
                  output fg_color, output bkgd_color, output flash, output conceal,
                  output cursor_on, input ready);
  modport sink (input valid, input last, input cell_kind, input row, input col,
                input char_code, input is_mosaic, input separated,
                input fg_color, input bkgd_color, input flash, input conceal,
                input cursor_on, output ready);
endinterface

[rtl/vdbs_front.sv]
// Front end: accepts a byte, updates cursor and attribute state, builds a command.
`timescale 1ns / 1ps

module vdbs_front #(
  parameter int unsigned COLUMNS = vdbs_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = vdbs_pkg::ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  vdbs_byte_if.sink         in_ch,
  input  logic              q_full,
  output logic              push,
  output vdbs_pkg::cmd_t    cmd
);
  import vdbs_pkg::*;

  logic [4:0] row_r, row_nxt;
  logic [5:0] col_r, col_nxt;
  logic [5:0] low_r, low_nxt;
  logic [2:0] afg_r, afg_nxt;
  logic [2:0] mfg_r, mfg_nxt;
  logic [2:0] bg_r, bg_nxt;
  mode_t      mode_r, mode_nxt;
  logic [8:0] held_r, held_nxt;
  logic       vis_r, vis_nxt;

  // The front takes a byte whenever the queue has a free slot.
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  // Classify the byte and work out the next state and the command.
  always_comb begin
    logic [6:0] b7;
    logic [3:0] rc;
    logic [2:0] cc;
    logic       attr_path;
    logic       prev_alpha;
    logic       p_afg_v, p_mfg_v, p_flash, p_rel, p_dbl;
    logic [2:0] p_afg, p_mfg;
    logic       draw;
    logic [8:0] glyph;

    b7         = in_ch.byte_in[6:0];
    rc         = b7[3:0];
    cc         = b7[6:4];
    attr_path  = 1'b0;
    prev_alpha = 1'b0;
    p_afg_v    = 1'b0;
    p_mfg_v    = 1'b0;
    p_flash    = 1'b0;
    p_rel      = 1'b0;
    p_dbl      = 1'b0;
    p_afg      = 3'd0;
    p_mfg      = 3'd0;
    draw       = 1'b0;
    glyph      = SPACE_GLYPH;

    row_nxt  = row_r;
    col_nxt  = col_r;
    low_nxt  = low_r;
    afg_nxt  = afg_r;
    mfg_nxt  = mfg_r;
    bg_nxt   = bg_r;
    mode_nxt = mode_r;
    held_nxt = held_r;
    vis_nxt  = vis_r;
    cmd      = '0;

    // Cursor control codes.
    case (b7)
      C_NUL: begin
      end
      C_BS: begin
        if (col_r == 6'd0) begin
          col_nxt = 6'(COLUMNS - 1);
          row_nxt = (row_r == 5'd0) ? 5'(ROWS - 1) : row_r - 5'd1;
        end else begin
          col_nxt = col_r - 6'd1;
        end
      end
      C_HT: begin
        col_nxt = col_r + 6'd1;
        if (col_nxt >= 6'(COLUMNS)) begin
          col_nxt = 6'd0;
          row_nxt = row_r + 5'd1;
          if (row_nxt >= 5'(ROWS)) begin
            row_nxt = 5'd0;
          end
        end
      end
      C_LF: begin
        row_nxt = row_r + 5'd1;
        if (row_nxt >= 5'(ROWS)) begin
          row_nxt = 5'd0;
        end
        bg_nxt   = 3'd0;
        afg_nxt  = 3'd7;
        mfg_nxt  = 3'd7;
        mode_nxt = MODE_RESET;
        held_nxt = SPACE_GLYPH;
      end
      C_VT: begin
        row_nxt = (row_r == 5'd0) ? 5'(ROWS - 1) : row_r - 5'd1;
      end
      C_FF: begin
        row_nxt      = 5'd0;
        col_nxt      = 6'd0;
        low_nxt      = LOW_NONE;
        bg_nxt       = 3'd0;
        afg_nxt      = 3'd7;
        mfg_nxt      = 3'd7;
        mode_nxt     = MODE_RESET;
        held_nxt     = SPACE_GLYPH;
        cmd.has_clr  = 1'b1;
      end
      C_CR: begin
        col_nxt = 6'd0;
      end
      C_DC1: begin
        vis_nxt = 1'b1;
      end
      C_DC4: begin
        vis_nxt = 1'b0;
      end
      C_RS: begin
        row_nxt = 5'd0;
        col_nxt = 6'd0;
      end
      default: begin
        attr_path = 1'b1;
      end
    endcase

    if (attr_path) begin
      // After an escape only bit 0 of the column survives.
      if (mode_r.esc) begin
        cc           = {2'b00, cc[0]};
        mode_nxt.esc = 1'b0;
      end

      // Set-at attributes act now; set-after ones are collected as pending.
      if (cc == COL_ATTR0) begin
        case (rc)
          A0_NUL, A0_END_BOX, A0_START_BOX, A0_SO, A0_SI: begin
          end
          A0_FLASH:  p_flash = 1'b1;
          A0_STEADY: mode_nxt.flash = 1'b0;
          A0_NORMAL: begin
            mode_nxt.dbl = 1'b0;
            held_nxt     = SPACE_GLYPH;
          end
          A0_DOUBLE: begin
            if (row_r < 5'(ROWS - 2) && {1'b0, row_r} != low_r) begin
              p_dbl = 1'b1;
            end
          end
          default: begin
            p_afg_v = 1'b1;
            p_afg   = rc[2:0];
          end
        endcase
      end else if (cc == COL_ATTR1) begin
        case (rc)
          A1_DLE: begin
          end
          A1_CONCEAL:   mode_nxt.conceal = 1'b1;
          A1_CONTIG:    mode_nxt.contig = 1'b1;
          A1_SEPARATED: mode_nxt.contig = 1'b0;
          A1_ESC:       mode_nxt.esc = 1'b1;
          A1_BLACK_BG:  bg_nxt = 3'd0;
          A1_NEW_BG:    bg_nxt = mode_nxt.alpha ? afg_nxt : mfg_nxt;
          A1_HOLD:      mode_nxt.hold = 1'b1;
          A1_RELEASE:   p_rel = 1'b1;
          default: begin
            p_mfg_v = 1'b1;
            p_mfg   = rc[2:0];
          end
        endcase
      end

      if (!(cc == COL_ATTR1 && rc == A1_ESC)) begin
        // Cell write, skipped on the lower half of a double-height row.
        draw = ({1'b0, row_r} != low_r);
        if (cc == COL_ATTR0 || cc == COL_ATTR1) begin
          glyph = mode_nxt.hold ? held_nxt : SPACE_GLYPH;
        end else begin
          glyph = {2'b00, b7};
          if (!mode_nxt.alpha) begin
            glyph[7] = 1'b1;
            glyph[8] = !mode_nxt.contig;
            if (draw) begin
              held_nxt = glyph;
            end
          end
        end
        cmd.has_cell  = draw;
        cmd.has_low   = draw && mode_nxt.dbl && (low_r != LOW_NONE);
        cmd.cell_kind = mode_nxt.dbl ? KIND_UPPER : KIND_SINGLE;
        cmd.cell_row  = row_r;
        cmd.cell_col  = col_r;
        cmd.low_row   = low_r[4:0];
        cmd.glyph     = glyph;
        cmd.fg        = mode_nxt.alpha ? afg_nxt : mfg_nxt;
        cmd.bg        = bg_nxt;
        cmd.flash     = mode_nxt.flash;
        cmd.conceal   = mode_nxt.conceal;

        // Set-after attributes take effect for the next cell.
        prev_alpha = mode_nxt.alpha;
        if (p_afg_v) begin
          afg_nxt          = p_afg;
          mode_nxt.alpha   = 1'b1;
          mode_nxt.conceal = 1'b0;
        end else if (p_mfg_v) begin
          mfg_nxt          = p_mfg;
          mode_nxt.alpha   = 1'b0;
          mode_nxt.conceal = 1'b0;
        end
        if (mode_nxt.alpha != prev_alpha) begin
          held_nxt = SPACE_GLYPH;
        end
        if (p_flash) begin
          mode_nxt.flash = 1'b1;
        end
        if (p_rel) begin
          mode_nxt.hold = 1'b0;
        end
        if (p_dbl) begin
          mode_nxt.dbl = 1'b1;
          low_nxt      = {1'b0, row_r} + 6'd1;
        end

        // Advance the column; the end of a row resets the row attributes.
        col_nxt = col_r + 6'd1;
        if (col_nxt >= 6'(COLUMNS)) begin
          row_nxt = row_r + 5'd1;
          if (row_nxt >= 5'(ROWS)) begin
            row_nxt = 5'd0;
          end
          col_nxt  = 6'd0;
          bg_nxt   = 3'd0;
          afg_nxt  = 3'd7;
          mfg_nxt  = 3'd7;
          mode_nxt = MODE_RESET;
          held_nxt = SPACE_GLYPH;
        end
      end
    end

    cmd.rep_row   = row_nxt;
    cmd.rep_col   = col_nxt;
    cmd.cursor_on = vis_nxt;
  end

  // Decoder state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= 5'd0;
      col_r  <= 6'd0;
      low_r  <= LOW_NONE;
      afg_r  <= 3'd7;
      mfg_r  <= 3'd7;
      bg_r   <= 3'd0;
      mode_r <= MODE_RESET;
      held_r <= SPACE_GLYPH;
      vis_r  <= 1'b0;
    end else if (push) begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      low_r  <= low_nxt;
      afg_r  <= afg_nxt;
      mfg_r  <= mfg_nxt;
      bg_r   <= bg_nxt;
      mode_r <= mode_nxt;
      held_r <= held_nxt;
      vis_r  <= vis_nxt;
    end
  end

  // The cursor always stays on the screen.
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r < 6'(COLUMNS))
    else $error("cursor column out of range");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_r < 5'(ROWS))
    else $error("cursor row out of range");

endmodule

[rtl/vdbs_queue.sv]
// Short command queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module vdbs_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  vdbs_pkg::cmd_t  push_cmd,
  input  logic            pop,
  output vdbs_pkg::cmd_t  head,
  output logic            empty,
  output logic            full
);
  import vdbs_pkg::*;

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign head  = q_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage, no reset needed.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("command queue fill count beyond its depth");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("command queue popped while empty");

endmodule

[rtl/vdbs_back.sv]
// Back end: expands each queued command into its results, one per cycle unless stalled.
`timescale 1ns / 1ps

module vdbs_back (
  input  logic            clk,
  input  logic            rst_n,
  input  vdbs_pkg::cmd_t  head,
  input  logic            q_empty,
  output logic            pop,
  vdbs_result_if.source   out_ch
);
  import vdbs_pkg::*;

  phase_t ph_r, ph_nxt;
  phase_t ph_eff;
  logic   out_valid_r, out_valid_nxt;
  res_t   res_r, res_nxt;
  logic   load;

  // Skip the phases the command has no result for.
  always_comb begin
    ph_eff = ph_r;
    if (ph_eff == PH_CLEAR && !head.has_clr) begin
      ph_eff = PH_CELL;
    end
    if (ph_eff == PH_CELL && !head.has_cell) begin
      ph_eff = PH_LOWER;
    end
    if (ph_eff == PH_LOWER && !head.has_low) begin
      ph_eff = PH_REPORT;
    end
  end

  // The output register takes a new result when it is empty or being drained.
  assign load = !q_empty && (!out_valid_r || out_ch.ready);

  // Next phase.
  always_comb begin
    ph_nxt = ph_r;
    if (load) begin
      case (ph_eff)
        PH_CLEAR:  ph_nxt = PH_CELL;
        PH_CELL:   ph_nxt = PH_LOWER;
        PH_LOWER:  ph_nxt = PH_REPORT;
        PH_REPORT: ph_nxt = PH_CLEAR;
        default:   ph_nxt = PH_CLEAR;
      endcase
    end
  end

  // Result of the current phase and the handshake outputs.
  always_comb begin
    res_nxt           = '0;
    res_nxt.cursor_on = head.cursor_on;
    case (ph_eff)
      PH_CLEAR: begin
        res_nxt.cell_kind = KIND_CLEAR;
      end
      PH_CELL, PH_LOWER: begin
        res_nxt.cell_kind  = (ph_eff == PH_LOWER) ? KIND_LOWER : head.cell_kind;
        res_nxt.row        = (ph_eff == PH_LOWER) ? head.low_row : head.cell_row;
        res_nxt.col        = head.cell_col;
        res_nxt.char_code  = head.glyph[6:0];
        res_nxt.is_mosaic  = head.glyph[7];
        res_nxt.separated  = head.glyph[8];
        res_nxt.fg_color   = head.fg;
        res_nxt.bkgd_color = head.bg;
        res_nxt.flash      = head.flash;
        res_nxt.conceal    = head.conceal;
      end
      PH_REPORT: begin
        res_nxt.last      = 1'b1;
        res_nxt.cell_kind = KIND_REPORT;
        res_nxt.row       = head.rep_row;
        res_nxt.col       = head.rep_col;
      end
      default: begin
        res_nxt.cell_kind = KIND_REPORT;
      end
    endcase
    pop           = load && (ph_eff == PH_REPORT);
    out_valid_nxt = load || (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      ph_r        <= ph_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.last       = res_r.last;
  assign out_ch.cell_kind  = res_r.cell_kind;
  assign out_ch.row        = res_r.row;
  assign out_ch.col        = res_r.col;
  assign out_ch.char_code  = res_r.char_code;
  assign out_ch.is_mosaic  = res_r.is_mosaic;
  assign out_ch.separated  = res_r.separated;
  assign out_ch.fg_color   = res_r.fg_color;
  assign out_ch.bkgd_color = res_r.bkgd_color;
  assign out_ch.flash      = res_r.flash;
  assign out_ch.conceal    = res_r.conceal;
  assign out_ch.cursor_on  = res_r.cursor_on;

  // The final result of a byte is always its cursor report.
  a_last_is_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.last |-> res_r.cell_kind == KIND_REPORT)
    else $error("last result is not a cursor report");

  // A command leaves the queue only after its report is loaded.
  a_pop_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> ph_r == PH_CLEAR && out_valid_r && res_r.last)
    else $error("command popped before its report");

endmodule

[rtl/viewdata_byte_stream_decoder.sv]
// Top level of the viewdata byte stream decoder: front end, command queue, back end.
// An accepted byte becomes a queued command, whose results are registered by the back end.
// Throughput: one result per cycle while out_ch is ready; a byte yields one to three results
//   (cell, lower half, clear screen, cursor report).
// A two-entry command queue lets new bytes be taken while earlier results drain.
// Reset (synchronous, active low): cursor at 0,0, row attributes at defaults, queue empty.
`timescale 1ns / 1ps

module viewdata_byte_stream_decoder #(
  parameter int unsigned COLUMNS = vdbs_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = vdbs_pkg::ROWS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  vdbs_byte_if.sink     in_ch,
  vdbs_result_if.source out_ch
);
  import vdbs_pkg::*;

  cmd_t push_cmd;
  cmd_t head;
  logic push;
  logic pop;
  logic q_empty;
  logic q_full;

  vdbs_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .cmd    (push_cmd)
  );

  vdbs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  vdbs_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
